// ===== design/thermal_frame_pec_decoder_core_macros.svh =====
// Assertion macros shared by the thermal frame PEC decoder RTL.
// Each user module must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef THERMAL_FRAME_PEC_DECODER_CORE_MACROS_SVH
`define THERMAL_FRAME_PEC_DECODER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define TFPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle
`define TFPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tfpd_pkg.sv =====
// Package for the thermal frame PEC decoder: constants, item type, CRC function.
// No dependencies; imported by every module of the block.
package tfpd_pkg;

    // Frame geometry
    localparam int PIXELS   = 1024;
    localparam int LAST_POS = 2 * PIXELS + 2;
    localparam int POS_W    = $clog2(LAST_POS + 1);
    localparam int IDX_W    = 10;

    // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [6:0] ADDR_RESET = 7'd10;

    // Divide by ten for values below the saturation limit
    localparam logic [15:0] SAT_LIMIT   = 16'd2560;
    localparam logic [10:0] DIV10_MUL   = 11'd1639;
    localparam int          DIV10_SHIFT = 14;
    localparam logic [7:0]  VALUE_MAX   = 8'd255;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_CHECK = 1'b1
    } t_kind;

    // One classified transaction on its way to the back end
    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   index;
        logic [15:0]        raw;
        logic [7:0]         crc;
        logic [7:0]         rcvd;
    } t_item;

    // Run one byte through the CRC register
    function automatic logic [7:0] crc8_byte(input logic [7:0] v);
        logic [7:0] x;
        x = v;
        for (int i = 0; i < 8; i++) begin
            x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        end
        return x;
    endfunction

    localparam logic [7:0] CRC_RESET = crc8_byte({ADDR_RESET, 1'b1});

endpackage

// ===== design/tfpd_front.sv =====
// Front end: takes frame bytes, tracks byte position and running CRC, classifies.
// Depends on tfpd_pkg; feeds tfpd_queue with pixel and check items.
module tfpd_front
    import tfpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    input  logic       i_cfg_valid,
    input  logic [6:0] i_cfg_sensor_address,
    output logic       o_wr,
    output t_item      o_item
);

    logic [6:0]       r_addr;
    logic [7:0]       r_crc,  n_crc;
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [7:0]       r_held, n_held;

    logic [POS_W-1:0] pos_cur;
    logic [POS_W-1:0] pix_off;
    logic [7:0]       seed;
    logic [7:0]       crc_cur;
    logic             is_pec;
    logic             is_pixel;

    // Address register; the user writes it only while block is idle; not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= ADDR_RESET;
        end else if (i_cfg_valid) begin
            r_addr <= i_cfg_sensor_address;
        end
    end

    // Classify the current byte
    always_comb begin
        pos_cur  = i_frame_start ? '0 : r_pos;
        seed     = crc8_byte({r_addr, 1'b1});
        crc_cur  = (pos_cur == '0) ? seed : r_crc;
        is_pec   = (pos_cur >= POS_W'(LAST_POS));
        is_pixel = !is_pec && pos_cur[0] && (pos_cur >= POS_W'(3));
        pix_off  = pos_cur - POS_W'(2);
    end

    // Next position, CRC and held low byte
    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_held = r_held;
        if (i_accept) begin
            if (is_pec) begin
                n_pos = '0;
                n_crc = seed;
            end else begin
                n_pos = pos_cur + POS_W'(1);
                n_crc = crc8_byte(i_data_byte ^ crc_cur);
                if (!pos_cur[0]) begin
                    n_held = i_data_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_crc  <= CRC_RESET;
            r_held <= '0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_held <= n_held;
        end
    end

    // Build the queue transaction; unused fields are zero
    always_comb begin
        o_wr   = i_accept && (is_pec || is_pixel);
        o_item = '0;
        if (is_pec) begin
            o_item.kind = KIND_CHECK;
            o_item.crc  = crc_cur;
            o_item.rcvd = i_data_byte;
        end else begin
            o_item.kind  = KIND_PIXEL;
            o_item.index = IDX_W'(pix_off >> 1);
            o_item.raw   = {i_data_byte, r_held};
        end
    end

endmodule

// ===== design/tfpd_queue.sv =====
// Short register queue that decouples the front end from the back end.
// Depends on tfpd_pkg for the item type and depth.
`include "thermal_frame_pec_decoder_core_macros.svh"

module tfpd_queue
    import tfpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_rd,
    output t_item o_item,
    output logic  o_empty
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `TFPD_ASSERT(a_no_overflow, !(i_wr && o_full), "queue written while full")
    `TFPD_ASSERT(a_no_underflow, !(i_rd && o_empty), "queue read while empty")
    `TFPD_ASSERT_NEXT(a_count_track, i_wr && !i_rd, r_count == $past(r_count) + QCNT_W'(1), "fill count did not advance on write")

endmodule

// ===== design/tfpd_back.sv =====
// Back end: converts pixel items to whole degrees and holds the result register.
// Depends on tfpd_pkg; reads from tfpd_queue.
`include "thermal_frame_pec_decoder_core_macros.svh"

module tfpd_back
    import tfpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic             i_q_empty,
    output logic             o_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_result_kind,
    output logic [IDX_W-1:0] o_pixel_index,
    output logic [7:0]       o_pixel_value,
    output logic [7:0]       o_computed_crc,
    output logic [7:0]       o_received_crc,
    output logic             o_pec_ok,
    output logic             o_frame_last
);

    logic             r_valid, n_valid;
    t_kind            r_kind;
    logic [IDX_W-1:0] r_index;
    logic [7:0]       r_value;
    logic [7:0]       r_crc;
    logic [7:0]       r_rcvd;
    logic             r_ok;

    logic [22:0]      prod;
    logic [7:0]       value;

    // Take the next item whenever the result register is free or being drained
    assign o_rd = !i_q_empty && (!r_valid || i_pop);

    // Divide by ten via reciprocal multiply, exact below limit; clamps to 0..255
    always_comb begin
        prod = 23'(i_item.raw[11:0]) * 23'(DIV10_MUL);
        priority if (i_item.raw[15]) begin
            value = '0;
        end else if (i_item.raw >= SAT_LIMIT) begin
            value = VALUE_MAX;
        end else begin
            value = prod[DIV10_SHIFT +: 8];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (o_rd) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (o_rd) begin
            r_kind  <= i_item.kind;
            r_index <= i_item.index;
            r_value <= value;
            r_crc   <= i_item.crc;
            r_rcvd  <= i_item.rcvd;
            r_ok    <= (i_item.kind == KIND_CHECK) && (i_item.crc == i_item.rcvd);
        end
    end

    assign o_empty        = !r_valid;
    assign o_result_kind  = r_kind;
    assign o_pixel_index  = r_index;
    assign o_pixel_value  = r_value;
    assign o_computed_crc = r_crc;
    assign o_received_crc = r_rcvd;
    assign o_pec_ok       = r_ok;
    assign o_frame_last   = (r_kind == KIND_CHECK);

    `TFPD_ASSERT_NEXT(a_hold_result, r_valid && !i_pop, r_valid && $stable(r_value) && $stable(r_kind), "result changed while stalled")
    `TFPD_ASSERT(a_check_zero_pixel, !(r_valid && r_kind == KIND_CHECK) || (r_value == '0 && r_index == '0), "check result carries pixel data")
    `TFPD_ASSERT(a_pixel_zero_crc, !(r_valid && r_kind == KIND_PIXEL) || (!r_ok && r_crc == '0 && r_rcvd == '0), "pixel result carries CRC data")

endmodule

// ===== design/thermal_frame_pec_decoder_core.sv =====
// Thermal frame PEC decoder: bytes in, pixel and PEC check results out.
// Channels: input queue push/full with i_data_byte and i_frame_start; result
// queue empty/pop with the result fields; config write i_cfg_valid/o_cfg_ready
// carrying the 7-bit sensor address (ready is always high).
// A frame is two reference bytes, 2*PIXELS pixel bytes (low byte first), one
// PEC byte. Each pixel high byte yields a pixel result; the PEC byte yields a
// check result with frame_last set. Other bytes yield nothing.
// One byte is accepted per cycle while full is low. A result passes through
// the four-entry queue, which the front end writes when its byte is accepted,
// and then the result register, which the divide-by-ten stage loads once it
// is free or being popped. When pop is held low the result register holds,
// the queue fills and full rises once five results wait (one presented, four
// queued); quiet bytes also wait on full.
// An address write takes effect from the next byte that starts a frame.
// Reset clears the queue and result register, sets the address to 10 and
// restarts at the first byte of a frame.
// Depends on tfpd_pkg, tfpd_front, tfpd_queue and tfpd_back.
module thermal_frame_pec_decoder_core
    import tfpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_frame_start,
    output logic             empty,
    input  logic             pop,
    output logic             o_result_kind,
    output logic [IDX_W-1:0] o_pixel_index,
    output logic [7:0]       o_pixel_value,
    output logic [7:0]       o_computed_crc,
    output logic [7:0]       o_received_crc,
    output logic             o_pec_ok,
    output logic             o_frame_last,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [6:0]       i_cfg_sensor_address
);

    logic  accept;
    logic  q_wr;
    logic  q_rd;
    logic  q_empty;
    t_item wr_item;
    t_item rd_item;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    // Classify bytes and run the CRC
    tfpd_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept),
        .i_data_byte          (i_data_byte),
        .i_frame_start        (i_frame_start),
        .i_cfg_valid          (i_cfg_valid && o_cfg_ready),
        .i_cfg_sensor_address (i_cfg_sensor_address),
        .o_wr                 (q_wr),
        .o_item               (wr_item)
    );

    // Decouple front and back
    tfpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (wr_item),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_item  (rd_item),
        .o_empty (q_empty)
    );

    // Convert and present results
    tfpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (rd_item),
        .i_q_empty      (q_empty),
        .o_rd           (q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result_kind  (o_result_kind),
        .o_pixel_index  (o_pixel_index),
        .o_pixel_value  (o_pixel_value),
        .o_computed_crc (o_computed_crc),
        .o_received_crc (o_received_crc),
        .o_pec_ok       (o_pec_ok),
        .o_frame_last   (o_frame_last)
    );

endmodule
